>>> sv/pts_pkg.sv
// shared types and constants for the page table store
// no dependencies; imported by every module of the block
package pts_pkg;

	// defaults for the top-level parameters
	localparam int LEVEL_BITS_DEF = 10;
	localparam int FRAME_BITS_DEF = 20;
	localparam int FLAG_BITS_DEF  = 8;

	// fixed payload and register widths
	localparam int CMD_W   = 2;
	localparam int VA_W    = 32;
	localparam int FRAME_W = 20;
	localparam int FLAG_W  = 8;
	localparam int TOTAL_W = 21;
	localparam int SHIFT_W = 5;
	localparam int COUNT_W = 21;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// flag bit positions
	localparam int FLAG_VALID    = 0;
	localparam int FLAG_DIRTY    = 1;
	localparam int FLAG_ACCESSED = 2;

	// register word indexes (paddr[3:2])
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SHIFT = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	// register reset values
	localparam logic               MODE_RST  = 1'b0;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
	localparam logic [COUNT_W-1:0] COUNT_RST = 21'h100000;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_MAP    = 2'd1,
		CMD_UNMAP  = 2'd2,
		CMD_DA     = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic [VA_W-1:0]    virtual_address;
		logic [FRAME_W-1:0] new_frame;
		logic [FLAG_W-1:0]  new_flags;
		logic               dirty_value;
		logic               accessed_value;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] frame_out;
		logic [FLAG_W-1:0]  flags_out;
		logic [TOTAL_W-1:0] valid_total;
	} rsp_t;

	typedef struct packed {
		logic               two_level_mode;
		logic [SHIFT_W-1:0] page_shift;
		logic [COUNT_W-1:0] page_count;
	} cfg_t;

	// classified command as it travels from front to back
	typedef struct packed {
		req_t            item;
		logic            level_split;
		logic            reject;
		logic [VA_W-1:0] vpn;
	} work_t;

endpackage

>>> sv/page_table_store.sv
// top level of the page table store: config registers and front/queue/back
// depends on pts_pkg, pts_front, pts_queue, pts_back
//
// Page table store. Each command transfer on req names a virtual address; its
// page number is the address shifted right by page_shift. Single-level mode
// indexes the entry store with the page number and rejects numbers at or above
// page_count or the store depth; two-level mode splits the low 2*LEVEL_BITS
// page-number bits into a block index and an entry index, and only map may
// allocate a block. Every command yields exactly one transfer on rsp, in order,
// carrying found, the entry's frame and flags after the command (zero when not
// found) and the running count of valid entries. The back end does one
// read-modify-write per command through a single-port entry memory: one step
// to read, one to modify and write back; it takes the next command only once
// the last has written back and the result register can take its result. A
// 2-deep queue sits between the front end and the back end, so req keeps
// taking transfers while a result waits on rsp; the result is registered.
// After reset the store is swept to zero one entry a cycle, with req_ready
// low; register writes are taken throughout.
// Registers sit at byte addresses 0 (two_level_mode), 4 (page_shift) and
// 8 (page_count); write them only while no command is in flight.
module page_table_store #(
	parameter int LEVEL_BITS = pts_pkg::LEVEL_BITS_DEF,
	parameter int FRAME_BITS = pts_pkg::FRAME_BITS_DEF,
	parameter int FLAG_BITS  = pts_pkg::FLAG_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pts_pkg::PADDR_W-1:0]  paddr,
	input  logic [pts_pkg::PDATA_W-1:0]  pwdata,
	output logic [pts_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// command channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  pts_pkg::req_t                req,
	// result channel
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output pts_pkg::rsp_t                rsp
);
	import pts_pkg::*;

	cfg_t  cfg_q;
	logic  cfg_write;
	logic  clearing;
	logic  push_valid;
	logic  push_ready;
	work_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	work_t pop_data;

	// register write completes on the access phase; no wait states
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_level_mode <= MODE_RST;
			cfg_q.page_shift     <= SHIFT_RST;
			cfg_q.page_count     <= COUNT_RST;
		end else if (cfg_write) begin
			case (paddr[PADDR_W-1:2])
				REG_MODE: begin
					cfg_q.two_level_mode <= pwdata[0];
				end
				REG_SHIFT: begin
					cfg_q.page_shift <= pwdata[SHIFT_W-1:0];
				end
				REG_COUNT: begin
					cfg_q.page_count <= pwdata[COUNT_W-1:0];
				end
				default: begin
					// unused word, write dropped
				end
			endcase
		end
	end

	// read back, zero for unused words
	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_MODE: begin
				prdata = PDATA_W'(cfg_q.two_level_mode);
			end
			REG_SHIFT: begin
				prdata = PDATA_W'(cfg_q.page_shift);
			end
			REG_COUNT: begin
				prdata = PDATA_W'(cfg_q.page_count);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// front end: page number and single-level range check
	pts_front #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_front (
		.req        (req),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cfg        (cfg_q),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue so the front keeps taking transfers while the back works
	pts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back end: memories, valid count and result register
	pts_back #(
		.LEVEL_BITS (LEVEL_BITS),
		.FRAME_BITS (FRAME_BITS),
		.FLAG_BITS  (FLAG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.clearing  (clearing)
	);

endmodule

>>> sv/pts_front.sv
// front end: takes command transfers, computes page number and range check
// depends on pts_pkg
module pts_front #(
	parameter int LEVEL_BITS = pts_pkg::LEVEL_BITS_DEF
) (
	input  pts_pkg::req_t  req,
	input  logic           req_valid,
	output logic           req_ready,
	input  pts_pkg::cfg_t  cfg,
	input  logic           clearing,
	output logic           push_valid,
	input  logic           push_ready,
	output pts_pkg::work_t push_data
);
	import pts_pkg::*;

	localparam int IDX_W = 2 * LEVEL_BITS;

	logic [VA_W-1:0] vpn;
	logic            above_count;
	logic            above_store;

	assign vpn         = req.virtual_address >> cfg.page_shift;
	assign above_count = vpn >= VA_W'(cfg.page_count);
	assign above_store = |vpn[VA_W-1:IDX_W];

	assign push_data.item        = req;
	assign push_data.level_split = cfg.two_level_mode;
	assign push_data.reject      = !cfg.two_level_mode && (above_count || above_store);
	assign push_data.vpn         = vpn;

	// hold off transfers while the entry store is being cleared
	assign push_valid = req_valid && !clearing;
	assign req_ready  = push_ready && !clearing;

endmodule

>>> sv/pts_queue.sv
// short fifo of classified commands between front and back
// depends on pts_pkg
module pts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pts_pkg::work_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pts_pkg::work_t pop_data
);
	import pts_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	work_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign push_ready = fill_q != FILL_W'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: begin
					fill_q <= fill_q + 1'b1;
				end
				2'b01: begin
					fill_q <= fill_q - 1'b1;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/pts_back.sv
// back end: read-modify-write of the entry and block memories, result register
// depends on pts_pkg
module pts_back #(
	parameter int LEVEL_BITS = pts_pkg::LEVEL_BITS_DEF,
	parameter int FRAME_BITS = pts_pkg::FRAME_BITS_DEF,
	parameter int FLAG_BITS  = pts_pkg::FLAG_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  pts_pkg::work_t pop_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pts_pkg::rsp_t  rsp,
	output logic           clearing
);
	import pts_pkg::*;

	localparam int IDX_W       = 2 * LEVEL_BITS;
	localparam int ENTRY_COUNT = 1 << IDX_W;
	localparam int BLOCK_COUNT = 1 << LEVEL_BITS;
	localparam int CNT_W       = IDX_W + 1;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic [FLAG_BITS-1:0]  flags;
	} entry_t;

	entry_t entry_mem [ENTRY_COUNT];
	logic   blk_mem [BLOCK_COUNT];
	entry_t rd_entry_q;
	logic   rd_blk_q;

	state_t           state_q;
	work_t            work_q;
	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [CNT_W-1:0] total_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic                  pop;
	logic [IDX_W-1:0]      rd_idx;
	logic [IDX_W-1:0]      wr_idx;
	logic [LEVEL_BITS-1:0] rd_blk;
	logic [LEVEL_BITS-1:0] wr_blk;
	logic                  hit;
	logic                  was_valid;
	logic                  ent_we;
	logic                  blk_we;
	entry_t                next_entry;
	logic [CNT_W-1:0]      next_total;

	assign pop_ready = (state_q == S_IDLE) && !clearing_q && (!rsp_valid_q || rsp_ready);
	assign pop       = pop_valid && pop_ready;

	assign rd_idx = pop_data.vpn[IDX_W-1:0];
	assign rd_blk = pop_data.vpn[IDX_W-1:LEVEL_BITS];
	assign wr_idx = work_q.vpn[IDX_W-1:0];
	assign wr_blk = work_q.vpn[IDX_W-1:LEVEL_BITS];

	always_comb begin
		hit = !work_q.reject
			&& (!work_q.level_split || rd_blk_q || (work_q.item.command == CMD_MAP));
		was_valid  = rd_entry_q.flags[FLAG_VALID];
		next_entry = rd_entry_q;
		next_total = total_q;
		case (work_q.item.command)
			CMD_MAP: begin
				next_entry.frame             = FRAME_BITS'(work_q.item.new_frame);
				next_entry.flags             = FLAG_BITS'(work_q.item.new_flags);
				next_entry.flags[FLAG_VALID] = 1'b1;
				if (!was_valid) begin
					next_total = total_q + 1'b1;
				end
			end
			CMD_UNMAP: begin
				next_entry.flags[FLAG_VALID] = 1'b0;
				if (was_valid) begin
					next_total = total_q - 1'b1;
				end
			end
			CMD_DA: begin
				next_entry.flags[FLAG_DIRTY]    = work_q.item.dirty_value;
				next_entry.flags[FLAG_ACCESSED] = work_q.item.accessed_value;
			end
			default: begin
			end
		endcase
		if (!hit) begin
			next_total = total_q;
		end
		ent_we = (state_q == S_EXEC) && hit && (work_q.item.command != CMD_LOOKUP);
		blk_we = (state_q == S_EXEC) && hit && work_q.level_split
			&& (work_q.item.command == CMD_MAP) && !rd_blk_q;
	end

	// single-port memories: clearing sweep, write-back, or read at pop
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			entry_mem[clr_addr_q]               <= '0;
			blk_mem[clr_addr_q[LEVEL_BITS-1:0]] <= 1'b0;
		end else begin
			if (ent_we) begin
				entry_mem[wr_idx] <= next_entry;
			end
			if (blk_we) begin
				blk_mem[wr_blk] <= 1'b1;
			end
			if (pop) begin
				rd_entry_q <= entry_mem[rd_idx];
				rd_blk_q   <= blk_mem[rd_blk];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			work_q      <= '0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						work_q  <= pop_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					total_q               <= next_total;
					rsp_valid_q           <= 1'b1;
					rsp_q.found           <= hit;
					rsp_q.frame_out       <= hit ? FRAME_W'(next_entry.frame) : '0;
					rsp_q.flags_out       <= hit ? FLAG_W'(next_entry.flags) : '0;
					rsp_q.valid_total     <= TOTAL_W'(next_total);
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign clearing  = clearing_q;

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_IDLE)
		else $error("execute step lasted more than one cycle");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> !rsp_valid_q)
		else $error("result register still occupied at execute");

	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !rsp_valid_q && state_q == S_IDLE)
		else $error("command in flight during clearing sweep");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(ENTRY_COUNT))
		else $error("valid entry count above store depth");

endmodule

>>> tb/sv/tb_page_table_store.sv
`timescale 1ns / 1ps
// self-checking testbench for page_table_store: directed and random command streams
// depends on pts_pkg and the page_table_store rtl; checks every result against its own model
module tb_page_table_store;
	import pts_pkg::*;

	localparam int SLOT_W = 2 * LEVEL_BITS_DEF;
	// the post-reset sweep alone idles req; the limit is four times the store depth
	localparam int WATCHDOG_LIMIT = 4 * (1 << SLOT_W);
	// one long receiver hold-off once this many results have been seen
	localparam int HOLD_AT  = 400;
	localparam int HOLD_LEN = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	page_table_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// commands waiting to be driven, and results the model says must come back
	req_t pending_cmds[$];
	rsp_t expected_rsp[$];

	// model of the store: sparse entries, block allocation bits, valid count
	logic [FRAME_W-1:0] frame_mem[int unsigned];
	logic [FLAG_W-1:0] flags_mem[int unsigned];
	logic block_live[1 << LEVEL_BITS_DEF];
	logic [TOTAL_W-1:0] valid_entries = '0;

	// model copy of the registers, updated on each accepted register write
	logic cfg_tiered = MODE_RST;
	logic [SHIFT_W-1:0] cfg_shift = SHIFT_RST;
	logic [COUNT_W-1:0] cfg_count = COUNT_RST;

	// settings the stimulus generator is currently building for
	logic gen_tiered = MODE_RST;
	logic [SHIFT_W-1:0] gen_shift = SHIFT_RST;
	logic [COUNT_W-1:0] gen_count = COUNT_RST;
	logic burst_mode = 1'b0;

	int errors = 0;
	int results_seen = 0;
	int hits = 0;
	int settings_run = 0;
	int idle_cycles = 0;
	logic req_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	logic held = 1'b0;

	initial begin
		foreach (block_live[i])
			block_live[i] = 1'b0;
	end

	// gap length for either side: mostly none or short, sometimes long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// apply one command to the model store and return the result it must give
	function automatic rsp_t apply_command(req_t it);
		logic [VA_W-1:0] vpn;
		int unsigned slot;
		logic [LEVEL_BITS_DEF-1:0] blk;
		logic reachable;
		logic [FRAME_W-1:0] frame;
		logic [FLAG_W-1:0] flags;
		rsp_t res;
		vpn = it.virtual_address >> cfg_shift;
		slot = 32'(vpn[SLOT_W-1:0]);
		blk = vpn[SLOT_W-1:LEVEL_BITS_DEF];
		// single-level: bounded by page_count and by the store depth
		if (!cfg_tiered)
			reachable = (vpn < VA_W'(cfg_count)) && (vpn < (32'd1 << SLOT_W));
		else if (block_live[blk])
			reachable = 1'b1;
		else if (it.command == CMD_MAP) begin
			// only a map allocates; old entry contents survive allocation
			block_live[blk] = 1'b1;
			reachable = 1'b1;
		end else
			reachable = 1'b0;
		res = '0;
		if (reachable) begin
			frame = frame_mem.exists(slot) ? frame_mem[slot] : '0;
			flags = flags_mem.exists(slot) ? flags_mem[slot] : '0;
			case (it.command)
			CMD_LOOKUP: ;
			CMD_MAP: begin
				if (!flags[FLAG_VALID])
					valid_entries++;
				frame = it.new_frame;
				flags = it.new_flags;
				flags[FLAG_VALID] = 1'b1;
			end
			CMD_UNMAP: begin
				if (flags[FLAG_VALID])
					valid_entries--;
				flags[FLAG_VALID] = 1'b0;
			end
			CMD_DA: begin
				flags[FLAG_DIRTY] = it.dirty_value;
				flags[FLAG_ACCESSED] = it.accessed_value;
			end
			default: ;
			endcase
			frame_mem[slot] = frame;
			flags_mem[slot] = flags;
			res.found = 1'b1;
			res.frame_out = frame;
			res.flags_out = flags;
		end
		res.valid_total = valid_entries;
		return res;
	endfunction

	// build a command for a page number under the current shift, random offset bits
	function automatic req_t make_item(cmd_t op, logic [VA_W-1:0] vpn);
		req_t it;
		logic [VA_W-1:0] low_mask;
		low_mask = (32'd1 << gen_shift) - 32'd1;
		it.command = op;
		it.virtual_address = (vpn << gen_shift) | ($urandom() & low_mask);
		it.new_frame = FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1));
		it.new_flags = FLAG_W'($urandom_range(0, (1 << FLAG_W) - 1));
		it.dirty_value = 1'($urandom_range(0, 1));
		it.accessed_value = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic cmd_t pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return CMD_MAP;
		if (r < 60)
			return CMD_LOOKUP;
		if (r < 75)
			return CMD_UNMAP;
		return CMD_DA;
	endfunction

	// wait until nothing is in flight, then let the back end settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// registers change only with the block idle
	task automatic apply_setting(input logic mode, input logic [SHIFT_W-1:0] shift,
			input logic [COUNT_W-1:0] pages);
		wait_idle();
		write_reg(REG_MODE, {31'b0, mode});
		write_reg(REG_SHIFT, {27'b0, shift});
		write_reg(REG_COUNT, {11'b0, pages});
		gen_tiered = mode;
		gen_shift = shift;
		gen_count = pages;
		settings_run++;
	endtask

	// random commands mostly aimed at a small pool of pages so maps get revisited
	task automatic queue_random(input int amount);
		logic [VA_W-1:0] pool[12];
		logic [LEVEL_BITS_DEF-1:0] blocks[3];
		longint top;
		longint hi;
		logic [VA_W-1:0] vpn;
		top = (64'd1 << (32 - gen_shift)) - 1;
		hi = longint'(gen_count) + 3;
		if (hi > top)
			hi = top;
		foreach (blocks[i])
			blocks[i] = LEVEL_BITS_DEF'($urandom_range(0, (1 << LEVEL_BITS_DEF) - 1));
		foreach (pool[i]) begin
			if (gen_tiered) begin
				// random upper bits are ignored in two-level mode
				pool[i] = $urandom();
				pool[i][SLOT_W-1:LEVEL_BITS_DEF] = blocks[$urandom_range(0, 2)];
			end else
				pool[i] = $urandom_range(0, int'(hi));
		end
		// page_count boundary, when the shift lets it be reached
		if (!gen_tiered && gen_count != 0 && longint'(gen_count) <= top) begin
			pool[0] = VA_W'(gen_count) - 1'b1;
			pool[1] = VA_W'(gen_count);
		end
		repeat (amount) begin
			if ($urandom_range(0, 99) < 85)
				vpn = pool[$urandom_range(0, 11)];
			else
				vpn = $urandom();
			pending_cmds.push_back(make_item(pick_command(), vpn));
		end
	endtask

	task automatic run_phase(input logic mode, input logic [SHIFT_W-1:0] shift,
			input logic [COUNT_W-1:0] pages, input int amount, input logic bursty);
		apply_setting(mode, shift, pages);
		burst_mode = bursty;
		queue_random(amount);
	endtask

	// stimulus and end of run
	initial begin
		req_t it;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-level directed: map, remap, flag updates, unmap twice, bounds
		apply_setting(1'b0, 5'd11, 21'h100000);
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h0));
		it = make_item(CMD_MAP, 32'h0);
		it.new_frame = '1;
		it.new_flags = '0;
		pending_cmds.push_back(it);
		// map over a valid entry leaves the count alone
		it = make_item(CMD_MAP, 32'h0);
		it.new_frame = '0;
		it.new_flags = '1;
		pending_cmds.push_back(it);
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h0));
		it = make_item(CMD_DA, 32'h0);
		it.dirty_value = 1'b1;
		it.accessed_value = 1'b0;
		pending_cmds.push_back(it);
		it = make_item(CMD_DA, 32'h0);
		it.dirty_value = 1'b0;
		it.accessed_value = 1'b1;
		pending_cmds.push_back(it);
		pending_cmds.push_back(make_item(CMD_UNMAP, 32'h0));
		// unmap of an invalid entry still hits
		pending_cmds.push_back(make_item(CMD_UNMAP, 32'h0));
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h0));
		// top entry of the store, kept for the shared-store check below
		it = make_item(CMD_MAP, 32'hFFFFF);
		it.new_frame = 20'hABCDE;
		it.new_flags = 8'h5A;
		pending_cmds.push_back(it);
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h100000));
		pending_cmds.push_back(make_item(CMD_MAP, 32'h1FFFFF));
		pending_cmds.push_back(make_item(CMD_DA, 32'h100000));

		// page_count above the store depth: depth still bounds
		apply_setting(1'b0, 5'd11, 21'h1FFFFF);
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h100000));
		pending_cmds.push_back(make_item(CMD_MAP, 32'h100001));

		// two-level directed: unallocated blocks, allocation, ignored upper bits
		apply_setting(1'b1, 5'd0, 21'h100000);
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h00000C00));
		pending_cmds.push_back(make_item(CMD_UNMAP, 32'h00000C00));
		pending_cmds.push_back(make_item(CMD_DA, 32'h00000C00));
		pending_cmds.push_back(make_item(CMD_MAP, 32'hFFF00C05));
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h00000C00));
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h000FFFFF));
		pending_cmds.push_back(make_item(CMD_MAP, 32'h000FFC00));
		// same store as single-level mode: the earlier top entry shows up here
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'hFFFFFFFF));
		pending_cmds.push_back(make_item(CMD_LOOKUP, 32'h0));

		// random part across register settings, extremes included
		run_phase(1'b0, 5'd12, 21'h100000, 250, 1'b0);
		run_phase(1'b0, 5'd0, 21'h0, 60, 1'b0);
		run_phase(1'b0, 5'd31, 21'h1, 60, 1'b1);
		run_phase(1'b1, 5'd12, 21'h0, 250, 1'b0);
		run_phase(1'b1, 5'd0, 21'h1FFFFF, 250, 1'b0);
		run_phase(1'b0, 5'd7, 21'h1FFFFF, 200, 1'b0);
		run_phase(1'b1, 5'd31, 21'h100000, 60, 1'b1);
		run_phase(1'b0, 5'd10, COUNT_W'($urandom_range(1, 4000)), 170, 1'b0);

		wait_idle();
		$display("%0d commands checked under %0d register settings", results_seen, settings_run);
		$display("%0d hits, %0d misses, %0d entries valid at the end", hits,
			results_seen - hits, valid_entries);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// command driver: valid holds until the transfer, then an optional gap
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (arst_n && pending_cmds.size() > 0) begin
				req <= pending_cmds.pop_front();
				req_valid <= 1'b1;
				gap_left <= idle_length();
			end else
				req_valid <= 1'b0;
		end
	end

	// result receiver: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (!held && results_seen >= HOLD_AT) begin
			held <= 1'b1;
			stall_left <= HOLD_LEN;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			stall_left <= idle_length();
		end
	end

	// monitor: register writes, command transfers into the model, result checks
	always @(posedge clk) begin : monitor
		rsp_t want;
		logic busy;
		busy = 1'b0;
		req_taken <= req_valid && req_ready;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				busy = 1'b1;
				case (paddr[3:2])
				REG_MODE: cfg_tiered = pwdata[0];
				REG_SHIFT: cfg_shift = pwdata[SHIFT_W-1:0];
				REG_COUNT: cfg_count = pwdata[COUNT_W-1:0];
				default: ;
				endcase
			end
			// check before predicting so a stray result cannot match a fresh command
			if (rsp_valid && rsp_ready) begin
				busy = 1'b1;
				results_seen++;
				if (expected_rsp.size() == 0) begin
					$display("%0t unexpected result transfer: got %p", $time, rsp);
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (want.found)
						hits++;
					if (rsp.found !== want.found) begin
						$display("%0t found mismatch: expected %0b, actual %0b", $time,
							want.found, rsp.found);
						errors++;
					end
					if (rsp.frame_out !== want.frame_out) begin
						$display("%0t frame_out mismatch: expected %h, actual %h", $time,
							want.frame_out, rsp.frame_out);
						errors++;
					end
					if (rsp.flags_out !== want.flags_out) begin
						$display("%0t flags_out mismatch: expected %h, actual %h", $time,
							want.flags_out, rsp.flags_out);
						errors++;
					end
					if (rsp.valid_total !== want.valid_total) begin
						$display("%0t valid_total mismatch: expected %0d, actual %0d", $time,
							want.valid_total, rsp.valid_total);
						errors++;
					end
				end
			end
			if (req_valid && req_ready) begin
				busy = 1'b1;
				expected_rsp.push_back(apply_command(req));
			end
		end
		// watchdog on cycles with no transfer of any kind
		idle_cycles = busy ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, expected_rsp.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

>>> filelist.f
sv/pts_pkg.sv
sv/pts_front.sv
sv/pts_queue.sv
sv/pts_back.sv
sv/page_table_store.sv
tb/sv/tb_page_table_store.sv
